// ===== hdl/frst_pkg.sv =====
// ----------------------------------------------------------------------------
// Frequency-ranked slot table package
// Shared widths, the slot entry layout, result codes and controller states.
// ----------------------------------------------------------------------------
package frst_pkg;

  // Fixed field widths of the table and of the result beat.
  localparam int HwSlots  = 32;
  localparam int CntW     = 6;
  localparam int OwnerW   = 8;
  localparam int VotesW   = 16;
  localparam int AgeW     = 32;
  localparam int SlotW    = 5;
  localparam int OutcomeW = 3;

  // Result codes carried on the outcome field.
  typedef enum logic [OutcomeW-1:0] {
    OC_COUNTED = 3'd0,
    OC_FREE    = 3'd1,
    OC_EVICT   = 3'd2,
    OC_ENTRY   = 3'd3,
    OC_EMPTY   = 3'd4
  } outcome_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VSCAN,
    ST_VDONE,
    ST_RSCAN,
    ST_RDONE
  } state_e;

  // One word of the slot memory.
  typedef struct packed {
    logic [OwnerW-1:0] owner;
    logic [VotesW-1:0] votes;
    logic [AgeW-1:0]   age;
  } entry_t;

endpackage

// ===== hdl/frst_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module frst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/frequency_ranked_slot_table_core.sv =====
// ----------------------------------------------------------------------------
// Frequency-ranked slot table core
// Holds candidate IDs with vote counts and insertion stamps in one slot
// memory; replaces the least-voted, earliest-inserted entry when full and
// lists held IDs in ascending order on request.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Handshake
//  --------  ----------------------------------------  -------------------------
//  command   start, cmd_i, candidate_i, busy           taken when start && !busy
//  result    strobe_o, outcome_o, slot_o, listed_id_o, one-cycle beat, no
//            vote_total_o, evicted_id_o, last_o        back-pressure
//  config    cfg_valid_i, cfg_data_i, cfg_ready_o      written on valid && ready
//
// A vote reads each held slot once on the single read port, drains the read
// pipeline and then writes back the chosen slot; the core stays busy until
// that write-back is done. A report makes one full memory scan per listed beat.
// An empty report or an ignored vote is handled without leaving the idle state.
// Reset empties the table at once; the slot memory itself is not cleared.
// A vote's result beat appears in the cycle after the write-back and is never held.

module frequency_ranked_slot_table_core #(
  parameter int SLOTS    = 32,
  parameter int ID_LIMIT = 255
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd_i,
  input  logic [frst_pkg::OwnerW-1:0]   candidate_i,
  output logic                          strobe_o,
  output logic [frst_pkg::OutcomeW-1:0] outcome_o,
  output logic [frst_pkg::SlotW-1:0]    slot_o,
  output logic [frst_pkg::OwnerW-1:0]   listed_id_o,
  output logic [frst_pkg::VotesW-1:0]   vote_total_o,
  output logic [frst_pkg::OwnerW-1:0]   evicted_id_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  input  logic [frst_pkg::CntW-1:0]     cfg_data_i,
  output logic                          cfg_ready_o
);

  import frst_pkg::*;

  localparam int Cap  = (SLOTS < HwSlots) ? SLOTS : HwSlots;
  localparam int IdxW = (Cap > 1) ? $clog2(Cap) : 1;
  localparam int KeyW = OwnerW + IdxW;

  // Control state.
  state_e            state_q, state_d;
  logic [CntW-1:0]   cfg_q, cfg_d;
  logic [CntW-1:0]   filled_q, filled_d;
  logic [AgeW-1:0]   clock_q, clock_d;
  logic [CntW-1:0]   iss_q, iss_d;
  logic              pend_q, pend_d;
  logic              strobe_q, strobe_d;

  // Scan and command registers.
  logic [IdxW-1:0]   pend_idx_q, pend_idx_d;
  logic [OwnerW-1:0] id_q, id_d;
  logic              m_found_q, m_found_d;
  logic [IdxW-1:0]   m_idx_q, m_idx_d;
  logic [VotesW-1:0] m_votes_q, m_votes_d;
  logic [AgeW-1:0]   m_age_q, m_age_d;
  logic [IdxW-1:0]   e_idx_q, e_idx_d;
  logic [VotesW-1:0] e_votes_q, e_votes_d;
  logic [AgeW-1:0]   e_age_q, e_age_d;
  logic [OwnerW-1:0] e_owner_q, e_owner_d;
  logic              best_found_q, best_found_d;
  logic [KeyW-1:0]   best_key_q, best_key_d;
  logic [VotesW-1:0] best_votes_q, best_votes_d;
  logic              prev_valid_q, prev_valid_d;
  logic [KeyW-1:0]   prev_key_q, prev_key_d;
  logic [CntW-1:0]   rep_cnt_q, rep_cnt_d;

  // Result beat registers.
  outcome_e          outcome_q, outcome_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [OwnerW-1:0] listed_q, listed_d;
  logic [VotesW-1:0] total_q, total_d;
  logic [OwnerW-1:0] evicted_q, evicted_d;
  logic              last_q, last_d;

  // Memory port signals.
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  entry_t            mem_wdata;
  logic [IdxW-1:0]   mem_raddr;
  entry_t            rd_e;

  logic [CntW-1:0]   limit;
  logic [CntW-1:0]   held;
  logic              accept;
  logic              id_ok;
  logic              iss_more;
  logic              scan_end;
  logic              rep_last;
  logic [KeyW-1:0]   rd_key;
  logic [VotesW-1:0] m_votes_inc;

  frst_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (Cap)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rd_e)
  );

  // Effective slot limit and number of held slots.
  always_comb begin
    if (cfg_q == '0) begin
      limit = CntW'(1);
    end else if (cfg_q > CntW'(Cap)) begin
      limit = CntW'(Cap);
    end else begin
      limit = cfg_q;
    end
    held = (filled_q < limit) ? filled_q : limit;
  end

  // Handshake and scan status.
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign accept      = start && !busy;
  assign id_ok       = (candidate_i != '0) && (32'(candidate_i) <= 32'(ID_LIMIT));
  assign iss_more    = (iss_q < held);
  assign scan_end    = !iss_more && !pend_q;
  assign rep_last    = ((rep_cnt_q + CntW'(1)) == held);
  assign rd_key      = {rd_e.owner, pend_idx_q};
  assign mem_raddr   = iss_q[IdxW-1:0];
  assign m_votes_inc = (m_votes_q == '1) ? m_votes_q : m_votes_q + VotesW'(1);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i) begin
            state_d = (held == '0) ? ST_IDLE : ST_RSCAN;
          end else begin
            state_d = id_ok ? ST_VSCAN : ST_IDLE;
          end
        end
      end
      ST_VSCAN: begin
        if (scan_end) begin
          state_d = ST_VDONE;
        end
      end
      ST_VDONE: begin
        state_d = ST_IDLE;
      end
      ST_RSCAN: begin
        if (scan_end) begin
          state_d = ST_RDONE;
        end
      end
      ST_RDONE: begin
        state_d = rep_last ? ST_IDLE : ST_RSCAN;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath, memory access and result beat.
  always_comb begin
    cfg_d        = cfg_q;
    filled_d     = filled_q;
    clock_d      = clock_q;
    iss_d        = iss_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    id_d         = id_q;
    m_found_d    = m_found_q;
    m_idx_d      = m_idx_q;
    m_votes_d    = m_votes_q;
    m_age_d      = m_age_q;
    e_idx_d      = e_idx_q;
    e_votes_d    = e_votes_q;
    e_age_d      = e_age_q;
    e_owner_d    = e_owner_q;
    best_found_d = best_found_q;
    best_key_d   = best_key_q;
    best_votes_d = best_votes_q;
    prev_valid_d = prev_valid_q;
    prev_key_d   = prev_key_q;
    rep_cnt_d    = rep_cnt_q;
    strobe_d     = 1'b0;
    outcome_d    = outcome_q;
    slot_d       = slot_q;
    listed_d     = listed_q;
    total_d      = total_q;
    evicted_d    = evicted_q;
    last_d       = last_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;

    if (cfg_valid_i && cfg_ready_o) begin
      cfg_d = cfg_data_i;
    end

    case (state_q)
      ST_IDLE: begin
        iss_d  = '0;
        pend_d = 1'b0;
        if (accept) begin
          id_d         = candidate_i;
          m_found_d    = 1'b0;
          best_found_d = 1'b0;
          prev_valid_d = 1'b0;
          rep_cnt_d    = '0;
          if (!cmd_i && id_ok && (clock_q != '1)) begin
            clock_d = clock_q + AgeW'(1);
          end
          if (cmd_i && (held == '0)) begin
            strobe_d  = 1'b1;
            outcome_d = OC_EMPTY;
            slot_d    = '0;
            listed_d  = '0;
            total_d   = '0;
            evicted_d = '0;
            last_d    = 1'b1;
          end
        end
      end

      ST_VSCAN, ST_RSCAN: begin
        // Issue one read a slot; the data returns in the next cycle.
        if (iss_more) begin
          iss_d      = iss_q + CntW'(1);
          pend_d     = 1'b1;
          pend_idx_d = iss_q[IdxW-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && (state_q == ST_VSCAN)) begin
          // Lowest matching slot, and least-voted then earliest entry.
          if (!m_found_q && (rd_e.owner == id_q)) begin
            m_found_d = 1'b1;
            m_idx_d   = pend_idx_q;
            m_votes_d = rd_e.votes;
            m_age_d   = rd_e.age;
          end
          if ((pend_idx_q == '0) || (rd_e.votes < e_votes_q) ||
              ((rd_e.votes == e_votes_q) && (rd_e.age < e_age_q))) begin
            e_idx_d   = pend_idx_q;
            e_votes_d = rd_e.votes;
            e_age_d   = rd_e.age;
            e_owner_d = rd_e.owner;
          end
        end
        if (pend_q && (state_q == ST_RSCAN)) begin
          // Smallest (ID, slot) key above the one listed last.
          if ((!prev_valid_q || (rd_key > prev_key_q)) &&
              (!best_found_q || (rd_key < best_key_q))) begin
            best_found_d = 1'b1;
            best_key_d   = rd_key;
            best_votes_d = rd_e.votes;
          end
        end
      end

      ST_VDONE: begin
        // Write back the chosen slot; the scan and this write never overlap.
        strobe_d  = 1'b1;
        listed_d  = id_q;
        last_d    = 1'b1;
        evicted_d = '0;
        mem_we    = 1'b1;
        if (m_found_q) begin
          mem_waddr = m_idx_q;
          mem_wdata = '{owner: id_q, votes: m_votes_inc, age: m_age_q};
          outcome_d = OC_COUNTED;
          slot_d    = SlotW'(m_idx_q);
          total_d   = m_votes_inc;
        end else if (filled_q < limit) begin
          mem_waddr = filled_q[IdxW-1:0];
          mem_wdata = '{owner: id_q, votes: VotesW'(1), age: clock_q};
          filled_d  = filled_q + CntW'(1);
          outcome_d = OC_FREE;
          slot_d    = SlotW'(filled_q[IdxW-1:0]);
          total_d   = VotesW'(1);
        end else begin
          mem_waddr = e_idx_q;
          mem_wdata = '{owner: id_q, votes: VotesW'(1), age: clock_q};
          outcome_d = OC_EVICT;
          slot_d    = SlotW'(e_idx_q);
          total_d   = VotesW'(1);
          evicted_d = e_owner_q;
        end
      end

      ST_RDONE: begin
        // List the entry found and prepare the next pass.
        strobe_d     = 1'b1;
        outcome_d    = OC_ENTRY;
        slot_d       = SlotW'(best_key_q[IdxW-1:0]);
        listed_d     = best_key_q[KeyW-1:IdxW];
        total_d      = best_votes_q;
        evicted_d    = '0;
        last_d       = rep_last;
        prev_valid_d = 1'b1;
        prev_key_d   = best_key_q;
        best_found_d = 1'b0;
        rep_cnt_d    = rep_cnt_q + CntW'(1);
        iss_d        = '0;
        pend_d       = 1'b0;
      end

      default: begin
        iss_d  = '0;
        pend_d = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cfg_q    <= CntW'(HwSlots);
      filled_q <= '0;
      clock_q  <= '0;
      iss_q    <= '0;
      pend_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cfg_q    <= cfg_d;
      filled_q <= filled_d;
      clock_q  <= clock_d;
      iss_q    <= iss_d;
      pend_q   <= pend_d;
      strobe_q <= strobe_d;
    end
  end

  // Scan and result payload registers.
  always_ff @(posedge clk_i) begin
    pend_idx_q   <= pend_idx_d;
    id_q         <= id_d;
    m_found_q    <= m_found_d;
    m_idx_q      <= m_idx_d;
    m_votes_q    <= m_votes_d;
    m_age_q      <= m_age_d;
    e_idx_q      <= e_idx_d;
    e_votes_q    <= e_votes_d;
    e_age_q      <= e_age_d;
    e_owner_q    <= e_owner_d;
    best_found_q <= best_found_d;
    best_key_q   <= best_key_d;
    best_votes_q <= best_votes_d;
    prev_valid_q <= prev_valid_d;
    prev_key_q   <= prev_key_d;
    rep_cnt_q    <= rep_cnt_d;
    outcome_q    <= outcome_d;
    slot_q       <= slot_d;
    listed_q     <= listed_d;
    total_q      <= total_d;
    evicted_q    <= evicted_d;
    last_q       <= last_d;
  end

  assign strobe_o     = strobe_q;
  assign outcome_o    = outcome_q;
  assign slot_o       = slot_q;
  assign listed_id_o  = listed_q;
  assign vote_total_o = total_q;
  assign evicted_id_o = evicted_q;
  assign last_o       = last_q;

endmodule

// ===== hdl/frst_checker.sv =====
// ----------------------------------------------------------------------------
// Frequency-ranked slot table port checker
// Watches the top-level ports for result beats that break the table's rules.
// ----------------------------------------------------------------------------
module frst_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          cmd_i,
  input logic                          strobe_o,
  input logic [frst_pkg::OutcomeW-1:0] outcome_o,
  input logic [frst_pkg::SlotW-1:0]    slot_o,
  input logic [frst_pkg::OwnerW-1:0]   listed_id_o,
  input logic [frst_pkg::VotesW-1:0]   vote_total_o,
  input logic [frst_pkg::OwnerW-1:0]   evicted_id_o,
  input logic                          last_o
);

  import frst_pkg::*;

  // A report always either starts a scan or answers empty at once.
  a_report_responds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i) |=> (busy || strobe_o))
    else $error("report command produced neither a scan nor a beat");

  // An empty report is a single, all-zero final beat.
  a_empty_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && (outcome_o == OC_EMPTY)) |->
      (last_o && (slot_o == '0) && (listed_id_o == '0) && (vote_total_o == '0)))
    else $error("empty report beat carries data");

  // A newly placed candidate starts with exactly one vote.
  a_placed_one_vote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && ((outcome_o == OC_FREE) || (outcome_o == OC_EVICT))) |->
      (last_o && (vote_total_o == VotesW'(1)) && (listed_id_o != '0)))
    else $error("placement beat with wrong vote total");

  // A counted vote names a real candidate and evicts nothing.
  a_counted_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && (outcome_o == OC_COUNTED)) |->
      (last_o && (listed_id_o != '0) && (vote_total_o != '0) && (evicted_id_o == '0)))
    else $error("counted beat inconsistent");

  // More report beats follow a non-final beat, so the block stays busy.
  a_nonlast_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_o) |-> busy)
    else $error("non-final beat while idle");

endmodule

bind frequency_ranked_slot_table_core frst_checker u_frst_checker (.*);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Frequency-ranked slot table testbench
// Drives votes and report commands into the slot table core, predicts every
// result beat from a behavioural copy of the table and checks each beat field
// by field. Directed tests cover the empty table, free-slot placement,
// eviction order, dormant duplicates, limit clamping and repeated votes for
// one ID. Three random phases with different sender idling follow.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import frst_pkg::*;

  localparam int TableSlots = 32;
  localparam int IdLimit    = 255;

  // Command codes on cmd_i.
  localparam logic CMD_VOTE   = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  // One expected result beat.
  typedef struct {
    outcome_e            outcome;
    logic [SlotW-1:0]    slot;
    logic [OwnerW-1:0]   id;
    logic [VotesW-1:0]   votes;
    logic [OwnerW-1:0]   evicted;
    logic                last;
  } beat_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                cmd_i;
  logic [OwnerW-1:0]   candidate_i;
  logic                strobe_o;
  logic [OutcomeW-1:0] outcome_o;
  logic [SlotW-1:0]    slot_o;
  logic [OwnerW-1:0]   listed_id_o;
  logic [VotesW-1:0]   vote_total_o;
  logic [OwnerW-1:0]   evicted_id_o;
  logic                last_o;
  logic                cfg_valid_i;
  logic [CntW-1:0]     cfg_data_i;
  logic                cfg_ready_o;

  // Behavioural copy of the table and its limit register.
  logic [OwnerW-1:0] held_owner [HwSlots];
  logic [VotesW-1:0] held_votes [HwSlots];
  logic [AgeW-1:0]   held_stamp [HwSlots];
  logic [CntW-1:0]   fill_level;
  logic [AgeW-1:0]   ballot_clock;
  logic [CntW-1:0]   slot_limit_reg;

  beat_t pending_beats[$];
  beat_t head_beat;

  int mismatch_count;
  int items_accepted;
  int reports_accepted;
  int ignored_votes;
  int beats_checked;
  int limit_writes;

  frequency_ranked_slot_table_core #(
    .SLOTS   (TableSlots),
    .ID_LIMIT(IdLimit)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .candidate_i (candidate_i),
    .strobe_o    (strobe_o),
    .outcome_o   (outcome_o),
    .slot_o      (slot_o),
    .listed_id_o (listed_id_o),
    .vote_total_o(vote_total_o),
    .evicted_id_o(evicted_id_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o)
  );

  // Free-running clock.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Prints one mismatch line and counts it.
  task automatic note_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH at %0t ns: %s", $realtime, msg);
  endtask

  function automatic void queue_beat(input outcome_e oc, input int unsigned slot_idx,
                                     input logic [OwnerW-1:0] id,
                                     input logic [VotesW-1:0] votes,
                                     input logic [OwnerW-1:0] evicted, input logic last);
    beat_t b;
    b.outcome = oc;
    b.slot    = slot_idx[SlotW-1:0];
    b.id      = id;
    b.votes   = votes;
    b.evicted = evicted;
    b.last    = last;
    pending_beats = {pending_beats, b};
  endfunction

  // Effective number of usable slots for a given limit register value.
  function automatic int unsigned usable_slots(input logic [CntW-1:0] reg_val);
    int unsigned cap;
    int unsigned n;
    cap = (TableSlots < HwSlots) ? TableSlots : HwSlots;
    n = reg_val;
    if (n < 1) n = 1;
    if (n > cap) n = cap;
    return n;
  endfunction

  // Applies one accepted command to the table copy and queues its beats.
  function automatic void compute_table_results(input logic cmd, input logic [OwnerW-1:0] cand);
    int unsigned lim;
    int unsigned held;
    int unsigned cnt;
    int unsigned pos;
    int unsigned loc;
    int unsigned order [HwSlots];
    logic [OwnerW-1:0] gone;
    lim  = usable_slots(slot_limit_reg);
    held = (fill_level < lim) ? fill_level : lim;

    if (cmd == CMD_REPORT) begin
      // Stable insertion sort by ID, so equal IDs stay in slot order.
      cnt = 0;
      for (int i = 0; i < held; i++) begin
        pos = cnt;
        while (pos > 0 && held_owner[order[pos-1]] > held_owner[i]) begin
          order[pos] = order[pos-1];
          pos--;
        end
        order[pos] = i;
        cnt++;
      end
      if (cnt == 0) begin
        queue_beat(OC_EMPTY, 0, '0, '0, '0, 1'b1);
        return;
      end
      for (int j = 0; j < cnt; j++) begin
        queue_beat(OC_ENTRY, order[j], held_owner[order[j]], held_votes[order[j]], '0,
                   (j + 1 == cnt));
      end
      return;
    end

    // Out-of-range IDs leave the table untouched.
    if (cand == 0 || cand > IdLimit) return;
    if (ballot_clock != '1) ballot_clock++;

    for (int i = 0; i < held; i++) begin
      if (held_owner[i] == cand) begin
        if (held_votes[i] != '1) held_votes[i]++;
        queue_beat(OC_COUNTED, i, cand, held_votes[i], '0, 1'b1);
        return;
      end
    end

    if (fill_level < lim) begin
      held_owner[fill_level] = cand;
      held_votes[fill_level] = VotesW'(1);
      held_stamp[fill_level] = ballot_clock;
      queue_beat(OC_FREE, fill_level, cand, VotesW'(1), '0, 1'b1);
      fill_level++;
      return;
    end

    // Fewest votes, then earliest stamp, then lowest slot.
    loc = 0;
    for (int i = 1; i < lim; i++) begin
      if (held_votes[i] < held_votes[loc] ||
          (held_votes[i] == held_votes[loc] && held_stamp[i] < held_stamp[loc]))
        loc = i;
    end
    gone = held_owner[loc];
    held_owner[loc] = cand;
    held_votes[loc] = VotesW'(1);
    held_stamp[loc] = ballot_clock;
    queue_beat(OC_EVICT, loc, cand, VotesW'(1), gone, 1'b1);
  endfunction

  // Result checker: every strobed beat is matched against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o === 1'b1) begin
      if (pending_beats.size() == 0) begin
        note_mismatch($sformatf("unexpected beat outcome=%0d slot=%0d id=%0d",
                                outcome_o, slot_o, listed_id_o));
      end else begin
        head_beat = pending_beats.pop_front();
        beats_checked++;
        if (outcome_o !== head_beat.outcome)
          note_mismatch($sformatf("outcome got %0d want %0d", outcome_o, head_beat.outcome));
        if (slot_o !== head_beat.slot)
          note_mismatch($sformatf("slot got %0d want %0d", slot_o, head_beat.slot));
        if (listed_id_o !== head_beat.id)
          note_mismatch($sformatf("listed_id got %0d want %0d", listed_id_o, head_beat.id));
        if (vote_total_o !== head_beat.votes)
          note_mismatch($sformatf("vote_total got %0d want %0d", vote_total_o,
                                  head_beat.votes));
        if (evicted_id_o !== head_beat.evicted)
          note_mismatch($sformatf("evicted_id got %0d want %0d", evicted_id_o,
                                  head_beat.evicted));
        if (last_o !== head_beat.last)
          note_mismatch($sformatf("last got %0d want %0d", last_o, head_beat.last));
      end
    end
  end

  // Presents one command and holds it until the core takes it.
  // Called at a rising edge; start is left high for a possible next command.
  task automatic send_item(input logic cmd, input logic [OwnerW-1:0] cand);
    start       <= 1'b1;
    cmd_i       <= cmd;
    candidate_i <= cand;
    do @(posedge clk_i); while (busy !== 1'b0);
    items_accepted++;
    if (cmd == CMD_REPORT) reports_accepted++;
    else if (cand == 0 || cand > IdLimit) ignored_votes++;
    compute_table_results(cmd, cand);
  endtask

  // Random sender idling: a geometric run of empty cycles, now and then a long one.
  task automatic sender_pause(input int idle_pct);
    int n;
    n = 0;
    while ($urandom_range(0, 99) < idle_pct) n++;
    if (n > 0 && $urandom_range(0, 7) == 0) n += $urandom_range(1, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Waits until every expected beat has arrived and the core is free.
  task automatic wait_until_quiet();
    while (pending_beats.size() != 0 || busy !== 1'b0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes the slot limit register once the core is idle.
  task automatic write_slot_limit(input logic [CntW-1:0] value);
    start <= 1'b0;
    wait_until_quiet();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    slot_limit_reg = value;
    limit_writes++;
  endtask

  // Report on an empty table and a vote for the reserved ID zero.
  task automatic test_empty_table();
    send_item(CMD_REPORT, 8'hFF);
    send_item(CMD_VOTE, 8'd0);
    send_item(CMD_REPORT, 8'd0);
  endtask

  // Free-slot placement, counting, a sorted report and eviction order.
  task automatic test_fill_count_evict();
    write_slot_limit(6'd3);
    send_item(CMD_VOTE, 8'd10);
    send_item(CMD_VOTE, 8'd255);
    send_item(CMD_VOTE, 8'd128);
    send_item(CMD_VOTE, 8'd10);
    send_item(CMD_REPORT, 8'd0);
    send_item(CMD_VOTE, 8'd1);
    send_item(CMD_VOTE, 8'd200);
    send_item(CMD_REPORT, 8'h5A);
  endtask

  // Shrinking the limit leaves dormant entries; growing it exposes a duplicate.
  task automatic test_dormant_entries();
    write_slot_limit(6'd1);
    send_item(CMD_VOTE, 8'd200);
    write_slot_limit(6'd3);
    send_item(CMD_VOTE, 8'd200);
    send_item(CMD_REPORT, 8'd0);
  endtask

  // Register values outside 1..32 are clamped.
  task automatic test_limit_clamp();
    write_slot_limit(6'd0);
    send_item(CMD_REPORT, 8'd0);
    send_item(CMD_VOTE, 8'd170);
    write_slot_limit(6'd63);
    send_item(CMD_VOTE, 8'd85);
    send_item(CMD_VOTE, 8'd170);
    send_item(CMD_REPORT, 8'd0);
  endtask

  // Piles votes onto one ID on a single-slot table, back to back, then
  // evicts it and exposes the slot behind it.
  task automatic test_repeated_votes();
    write_slot_limit(6'd1);
    repeat (10) send_item(CMD_VOTE, 8'd77);
    send_item(CMD_REPORT, 8'd0);
    send_item(CMD_VOTE, 8'd99);
    write_slot_limit(6'd2);
    send_item(CMD_REPORT, 8'd0);
  endtask

  // Random votes and reports, drawn mostly from a small pool of IDs so that
  // counting and eviction dominate; the limit is rewritten every 30 commands.
  task automatic test_random_traffic(input int idle_pct, input int n_items,
                                     input logic [CntW-1:0] first_limit);
    int done_items;
    int next_cfg_at;
    int pick;
    int unsigned pool_size;
    logic [OwnerW-1:0] id_pool [48];
    logic [CntW-1:0] lim_val;
    done_items  = 0;
    next_cfg_at = 0;
    while (done_items < n_items) begin
      if (done_items >= next_cfg_at) begin
        if (done_items == 0) lim_val = first_limit;
        else begin
          case ($urandom_range(0, 5))
            0:       lim_val = 6'd1;
            1:       lim_val = 6'd32;
            2:       lim_val = CntW'($urandom_range(2, 8));
            3:       lim_val = CntW'($urandom_range(9, 31));
            4:       lim_val = ($urandom_range(0, 1) != 0) ? 6'd0 :
                               CntW'($urandom_range(33, 63));
            default: lim_val = 6'd16;
          endcase
        end
        write_slot_limit(lim_val);
        pool_size = usable_slots(lim_val) + $urandom_range(1, 8);
        for (int k = 0; k < pool_size; k++) id_pool[k] = OwnerW'($urandom_range(1, IdLimit));
        next_cfg_at += 30;
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_item(CMD_REPORT, OwnerW'($urandom_range(0, 255)));
        done_items++;
      end else if (pick < 13) begin
        send_item(CMD_VOTE, 8'd0);
      end else if (pick < 33) begin
        send_item(CMD_VOTE, OwnerW'($urandom_range(1, IdLimit)));
        done_items++;
      end else begin
        send_item(CMD_VOTE, id_pool[$urandom_range(0, pool_size - 1)]);
        done_items++;
      end
      sender_pause(idle_pct);
    end
  endtask

  // Main sequence.
  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    cmd_i          = CMD_VOTE;
    candidate_i    = '0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    fill_level     = '0;
    ballot_clock   = '0;
    slot_limit_reg = 6'd32;
    mismatch_count = 0;
    items_accepted = 0;
    reports_accepted = 0;
    ignored_votes  = 0;
    beats_checked  = 0;
    limit_writes   = 0;
    for (int i = 0; i < HwSlots; i++) begin
      held_owner[i] = '0;
      held_votes[i] = '0;
      held_stamp[i] = '0;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_fill_count_evict();
    test_dormant_entries();
    test_limit_clamp();
    test_repeated_votes();
    test_random_traffic(38, 75, 6'd32);
    test_random_traffic(58, 75, 6'd1);
    test_random_traffic(0, 74, 6'd63);

    // Drain the remaining beats and give the core time to settle.
    start <= 1'b0;
    while (pending_beats.size() != 0 || busy !== 1'b0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (pending_beats.size() != 0)
      note_mismatch($sformatf("%0d expected beats never arrived", pending_beats.size()));

    $display("Run covered %0d commands (%0d reports, %0d ignored votes) and %0d limit writes.",
             items_accepted, reports_accepted, ignored_votes, limit_writes);
    $display("%0d result beats checked, %0d mismatches.", beats_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #80_000_000;
    $display("Timeout with %0d beats still expected.", pending_beats.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== frequency_ranked_slot_table_core.f =====
hdl/frst_pkg.sv
hdl/frst_ram.sv
hdl/frequency_ranked_slot_table_core.sv
hdl/frst_checker.sv
tb/tb.sv
